// ===== rtl/skt_pkg.sv =====
// Shared constants and codes for the sorted key table.
`default_nettype none
package skt_pkg;
	localparam int KEY_W      = 32;
	localparam int REF_W      = 16;
	localparam int CNT_OUT_W  = 7;
	localparam int OP_W       = 2;
	localparam int STATUS_W   = 2;
	localparam int DEPTH_DEF    = 64;
	localparam int REF_BITS_DEF = 16;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_res_t;
endpackage
`default_nettype wire

// ===== rtl/skt_mem.sv =====
// Entry storage: one write port and one registered read port.
`default_nettype none
module skt_mem #(
	parameter int DEPTH    = skt_pkg::DEPTH_DEF,
	parameter int REF_BITS = skt_pkg::REF_BITS_DEF,
	parameter int ADDR_W   = $clog2(DEPTH)
) (
	input  wire                             clk,
	input  wire                             we,
	input  wire        [ADDR_W-1:0]         waddr,
	input  wire signed [skt_pkg::KEY_W-1:0] wkey,
	input  wire        [REF_BITS-1:0]       wref,
	input  wire        [ADDR_W-1:0]         raddr,
	output logic signed [skt_pkg::KEY_W-1:0] rkey,
	output logic        [REF_BITS-1:0]       rref
);
	logic signed [skt_pkg::KEY_W-1:0] keys_q [DEPTH];
	logic        [REF_BITS-1:0]       refs_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			keys_q[waddr] <= wkey;
			refs_q[waddr] <= wref;
		end
		rkey <= keys_q[raddr];
		rref <= refs_q[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/skt_cmp.sv =====
// Shared signed key comparator.
`default_nettype none
module skt_cmp (
	input  wire signed [skt_pkg::KEY_W-1:0] a,
	input  wire signed [skt_pkg::KEY_W-1:0] b,
	output skt_pkg::cmp_res_t               res
);
	assign res.lt = (a < b);
	assign res.eq = (a == b);
endmodule
`default_nettype wire

// ===== rtl/skt_ctrl.sv =====
// Sequencer: scan, shift and result register around the shared comparator.
`default_nettype none
module skt_ctrl #(
	parameter int DEPTH    = skt_pkg::DEPTH_DEF,
	parameter int REF_BITS = skt_pkg::REF_BITS_DEF,
	parameter int ADDR_W   = $clog2(DEPTH),
	parameter int CNT_W    = $clog2(DEPTH + 1)
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire        [skt_pkg::OP_W-1:0]     in_op,
	input  wire signed [skt_pkg::KEY_W-1:0]    in_key,
	input  wire        [skt_pkg::REF_W-1:0]    in_ref,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic       [skt_pkg::STATUS_W-1:0] out_status,
	output logic signed [skt_pkg::KEY_W-1:0]   out_key,
	output logic       [skt_pkg::REF_W-1:0]    out_ref,
	output logic       [skt_pkg::CNT_OUT_W-1:0] out_count,
	output logic                               mem_we,
	output logic       [ADDR_W-1:0]            mem_waddr,
	output logic signed [skt_pkg::KEY_W-1:0]   mem_wkey,
	output logic       [REF_BITS-1:0]          mem_wref,
	output logic       [ADDR_W-1:0]            mem_raddr,
	input  wire signed [skt_pkg::KEY_W-1:0]    mem_rkey,
	input  wire        [REF_BITS-1:0]          mem_rref
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SRD  = 3'd1;
	localparam logic [2:0] S_SCMP = 3'd2;
	localparam logic [2:0] S_SHRD = 3'd3;
	localparam logic [2:0] S_SHWR = 3'd4;
	localparam logic [2:0] S_PUT  = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0]                       state_q;
	logic [skt_pkg::OP_W-1:0]         op_q;
	logic signed [skt_pkg::KEY_W-1:0] key_q;
	logic [REF_BITS-1:0]              ref_q;
	logic [CNT_W-1:0]                 count_q;
	logic [CNT_W-1:0]                 idx_q;
	logic [CNT_W-1:0]                 sh_q;
	logic [skt_pkg::STATUS_W-1:0]     st_q;
	logic signed [skt_pkg::KEY_W-1:0] kout_q;
	logic [REF_BITS-1:0]              rout_q;
	logic                             ovalid_q;
	logic [skt_pkg::STATUS_W-1:0]     ostatus_q;
	logic signed [skt_pkg::KEY_W-1:0] okey_q;
	logic [skt_pkg::REF_W-1:0]        oref_q;
	logic [skt_pkg::CNT_OUT_W-1:0]    ocount_q;

	logic [CNT_W-1:0]  sh_dec;
	logic [CNT_W-1:0]  sh_inc;
	logic              sh_last;
	logic              accept;
	skt_pkg::cmp_res_t cmp;

	skt_cmp u_cmp (
		.a   (mem_rkey),
		.b   (key_q),
		.res (cmp)
	);

	assign sh_dec  = sh_q - 1'b1;
	assign sh_inc  = sh_q + 1'b1;
	assign sh_last = ({1'b0, sh_q} + 1'b1) >= {1'b0, count_q};
	assign accept  = in_valid && in_ready;

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = ovalid_q;
	assign out_status = ostatus_q;
	assign out_key    = okey_q;
	assign out_ref    = oref_q;
	assign out_count  = ocount_q;

	always_comb begin
		mem_raddr = idx_q[ADDR_W-1:0];
		if (state_q == S_SHRD) begin
			mem_raddr = (op_q == skt_pkg::OP_INSERT) ? sh_dec[ADDR_W-1:0]
			                                         : sh_inc[ADDR_W-1:0];
		end
		mem_we    = (state_q == S_SHWR) || (state_q == S_PUT);
		mem_waddr = sh_q[ADDR_W-1:0];
		mem_wkey  = (state_q == S_PUT) ? key_q : mem_rkey;
		mem_wref  = (state_q == S_PUT) ? ref_q : mem_rref;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (ovalid_q && out_ready && state_q != S_DONE) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_op == skt_pkg::OP_INSERT) begin
							state_q <= (count_q == CNT_W'(DEPTH)) ? S_DONE : S_SRD;
						end else if (in_op == skt_pkg::OP_REMOVE ||
						             in_op == skt_pkg::OP_LOOKUP) begin
							state_q <= S_SRD;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SRD: begin
					if (idx_q == count_q) begin
						state_q <= (op_q == skt_pkg::OP_INSERT) ? S_SHRD : S_DONE;
					end else begin
						state_q <= S_SCMP;
					end
				end
				S_SCMP: begin
					if (op_q == skt_pkg::OP_INSERT) begin
						state_q <= cmp.lt ? S_SRD : S_SHRD;
					end else if (cmp.eq) begin
						state_q <= (op_q == skt_pkg::OP_REMOVE) ? S_SHRD : S_DONE;
					end else begin
						state_q <= S_SRD;
					end
				end
				S_SHRD: begin
					if (op_q == skt_pkg::OP_INSERT) begin
						state_q <= (sh_q == idx_q) ? S_PUT : S_SHWR;
					end else if (sh_last) begin
						count_q <= count_q - 1'b1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_SHWR;
					end
				end
				S_SHWR: begin
					state_q <= S_SHRD;
				end
				S_PUT: begin
					count_q <= count_q + 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!ovalid_q || out_ready) begin
						ovalid_q <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q   <= in_op;
				key_q  <= in_key;
				ref_q  <= REF_BITS'(in_ref);
				idx_q  <= '0;
				st_q   <= (in_op == skt_pkg::OP_INSERT) ? skt_pkg::ST_FULL
				                                        : skt_pkg::ST_NOT_FOUND;
				kout_q <= '0;
				rout_q <= '0;
			end
			S_SRD: begin
				sh_q <= count_q;
			end
			S_SCMP: begin
				if (op_q == skt_pkg::OP_INSERT) begin
					if (cmp.lt) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						sh_q <= count_q;
					end
				end else if (cmp.eq) begin
					sh_q   <= idx_q;
					st_q   <= skt_pkg::ST_DONE;
					kout_q <= mem_rkey;
					rout_q <= mem_rref;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			S_SHWR: begin
				sh_q <= (op_q == skt_pkg::OP_INSERT) ? sh_dec : sh_inc;
			end
			S_PUT: begin
				st_q   <= skt_pkg::ST_DONE;
				kout_q <= key_q;
			end
			S_DONE: begin
				if (!ovalid_q || out_ready) begin
					ostatus_q <= st_q;
					okey_q    <= kout_q;
					oref_q    <= skt_pkg::REF_W'(rout_q);
					ocount_q  <= skt_pkg::CNT_OUT_W'(count_q);
				end
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/sorted_key_table_top.sv =====
// Top level of the sorted key table: stream ports, storage and sequencer.
//
// channel | dir | tdata (low bit up)              | tuser
// s_axis  | in  | key[31:0], record_ref[47:32]     | opcode[1:0]
// m_axis  | out | key_out[31:0], ref_out[47:32],   | status[1:0]
//         |     | entry_count[54:48]               |
//
// One word at a time. An insert scans the entries in order up to the first
// one not below its key, a remove or lookup up to its match, each entry read
// and then compared; insert and remove then shift the entries behind that
// position one at a time, each read and then written. A miss scans all
// entries; a full insert or unused opcode goes straight to the result. Reset
// empties the table at once, no clearing pass. A stalled result holds the
// sequencer in its last step while the next word waits on s_axis_tready.
`default_nettype none
module sorted_key_table_top #(
	parameter int DEPTH    = skt_pkg::DEPTH_DEF,
	parameter int REF_BITS = skt_pkg::REF_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [47:0] s_axis_tdata,   // key[31:0], record_ref[47:32]
	input  wire  [1:0]  s_axis_tuser,   // opcode[1:0]
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [55:0] m_axis_tdata,   // key_out[31:0], ref_out[47:32], entry_count[54:48]
	output logic [1:0]  m_axis_tuser    // status[1:0]
);
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	logic [skt_pkg::STATUS_W-1:0]     status;
	logic signed [skt_pkg::KEY_W-1:0] key_out;
	logic [skt_pkg::REF_W-1:0]        ref_out;
	logic [skt_pkg::CNT_OUT_W-1:0]    entry_count;

	logic                             mem_we;
	logic [ADDR_W-1:0]                mem_waddr;
	logic signed [skt_pkg::KEY_W-1:0] mem_wkey;
	logic [REF_BITS-1:0]              mem_wref;
	logic [ADDR_W-1:0]                mem_raddr;
	logic signed [skt_pkg::KEY_W-1:0] mem_rkey;
	logic [REF_BITS-1:0]              mem_rref;

	skt_mem #(
		.DEPTH    (DEPTH),
		.REF_BITS (REF_BITS),
		.ADDR_W   (ADDR_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wkey  (mem_wkey),
		.wref  (mem_wref),
		.raddr (mem_raddr),
		.rkey  (mem_rkey),
		.rref  (mem_rref)
	);

	skt_ctrl #(
		.DEPTH    (DEPTH),
		.REF_BITS (REF_BITS),
		.ADDR_W   (ADDR_W),
		.CNT_W    (CNT_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_op      (s_axis_tuser),
		.in_key     (s_axis_tdata[31:0]),
		.in_ref     (s_axis_tdata[47:32]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (status),
		.out_key    (key_out),
		.out_ref    (ref_out),
		.out_count  (entry_count),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wkey   (mem_wkey),
		.mem_wref   (mem_wref),
		.mem_raddr  (mem_raddr),
		.mem_rkey   (mem_rkey),
		.mem_rref   (mem_rref)
	);

	assign m_axis_tdata = {1'b0, entry_count, ref_out, key_out};
	assign m_axis_tuser = status;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while a word is in work");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && status == skt_pkg::ST_FULL
		|-> entry_count == skt_pkg::CNT_OUT_W'(DEPTH))
		else $error("full reported below capacity");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && status != skt_pkg::ST_DONE
		|-> key_out == '0 && ref_out == '0)
		else $error("failed operation returned nonzero payload");

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> status == skt_pkg::ST_DONE ||
		status == skt_pkg::ST_NOT_FOUND || status == skt_pkg::ST_FULL)
		else $error("undefined status code");
endmodule
`default_nettype wire

// ===== tb/sorted_key_table_top_tb.sv =====
// Testbench for sorted_key_table_top: directed, full-table and random traffic.
`timescale 1ns / 1ps
module sorted_key_table_top_tb;
	localparam int DEPTH = skt_pkg::DEPTH_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [skt_pkg::OP_W-1:0] OP_SPARE = 2'd3;

	typedef struct packed {
		logic [skt_pkg::STATUS_W-1:0]  status;
		logic [skt_pkg::KEY_W-1:0]     key_out;
		logic [skt_pkg::REF_W-1:0]     ref_out;
		logic [skt_pkg::CNT_OUT_W-1:0] count;
	} table_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	logic signed [skt_pkg::KEY_W-1:0] held_key [DEPTH];
	logic [skt_pkg::REF_W-1:0]        held_ref [DEPTH];
	int                               held = 0;
	table_result_t                    pending_results [$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;
	int cycles = 0;
	table_result_t got, want;

	sorted_key_table_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t timeout with %0d results outstanding", $time,
				pending_results.size());
			$display("FAIL sorted_key_table_top");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic table_result_t apply_table_op(input logic [skt_pkg::OP_W-1:0] op,
			input logic signed [skt_pkg::KEY_W-1:0] k,
			input logic [skt_pkg::REF_W-1:0] r);
		table_result_t res;
		int pos;
		res = '{status: skt_pkg::ST_NOT_FOUND, key_out: '0, ref_out: '0, count: '0};
		pos = 0;
		if (op == skt_pkg::OP_INSERT) begin
			if (held >= DEPTH) begin
				res.status = skt_pkg::ST_FULL;
			end else begin
				while (pos < held && held_key[pos] < k)
					pos++;
				for (int i = held; i > pos; i--) begin
					held_key[i] = held_key[i-1];
					held_ref[i] = held_ref[i-1];
				end
				held_key[pos] = k;
				held_ref[pos] = r;
				held++;
				res.status = skt_pkg::ST_DONE;
				res.key_out = k;
			end
		end else if (op == skt_pkg::OP_REMOVE || op == skt_pkg::OP_LOOKUP) begin
			while (pos < held && held_key[pos] != k)
				pos++;
			if (pos < held) begin
				res.status = skt_pkg::ST_DONE;
				res.key_out = held_key[pos];
				res.ref_out = held_ref[pos];
				if (op == skt_pkg::OP_REMOVE) begin
					for (int i = pos; i + 1 < held; i++) begin
						held_key[i] = held_key[i+1];
						held_ref[i] = held_ref[i+1];
					end
					held--;
				end
			end
		end
		res.count = skt_pkg::CNT_OUT_W'(held);
		return res;
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.status = m_axis_tuser;
			got.key_out = m_axis_tdata[31:0];
			got.ref_out = m_axis_tdata[47:32];
			got.count = m_axis_tdata[54:48];
			if (pending_results.size() == 0) begin
				$display("%0t unexpected word: expected none, actual %h", $time, got);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status) begin
					$display("%0t status: expected %h, actual %h", $time, want.status,
						got.status);
					errors++;
				end
				if (got.key_out !== want.key_out) begin
					$display("%0t key_out: expected %h, actual %h", $time, want.key_out,
						got.key_out);
					errors++;
				end
				if (got.ref_out !== want.ref_out) begin
					$display("%0t ref_out: expected %h, actual %h", $time, want.ref_out,
						got.ref_out);
					errors++;
				end
				if (got.count !== want.count) begin
					$display("%0t entry_count: expected %0d, actual %0d", $time, want.count,
						got.count);
					errors++;
				end
			end
		end
	end

	task automatic send_word(input logic [skt_pkg::OP_W-1:0] op,
			input logic [skt_pkg::KEY_W-1:0] k, input logic [skt_pkg::REF_W-1:0] r);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {r, k};
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(apply_table_op(op, k, r));
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [skt_pkg::KEY_W-1:0] pick_key();
		int sel;
		sel = $urandom_range(99);
		if (held != 0 && sel < 45)
			return held_key[$urandom_range(held - 1)];
		if (sel < 75)
			return skt_pkg::KEY_W'(int'($urandom_range(16)) - 8);
		if (sel < 82) begin
			case ($urandom_range(3))
				0: return 32'h8000_0000;
				1: return 32'h7fff_ffff;
				2: return 32'h0000_0000;
				default: return 32'hffff_ffff;
			endcase
		end
		return $urandom();
	endfunction

	task automatic test_directed();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_word(skt_pkg::OP_LOOKUP, 32'd5, 16'h1234);
		send_word(skt_pkg::OP_REMOVE, 32'd5, 16'h0000);
		send_word(OP_SPARE, 32'd0, 16'hffff);
		send_word(skt_pkg::OP_INSERT, 32'h8000_0000, 16'h0000);
		send_word(skt_pkg::OP_INSERT, 32'h7fff_ffff, 16'hffff);
		send_word(skt_pkg::OP_INSERT, 32'd0, 16'h0001);
		send_word(skt_pkg::OP_INSERT, 32'd0, 16'h0002);
		send_word(skt_pkg::OP_INSERT, 32'hffff_ffff, 16'h0003);
		send_word(skt_pkg::OP_LOOKUP, 32'd0, 16'h0000);
		send_word(skt_pkg::OP_LOOKUP, 32'h8000_0000, 16'h0000);
		send_word(skt_pkg::OP_LOOKUP, 32'h7fff_ffff, 16'h0000);
		send_word(skt_pkg::OP_LOOKUP, 32'd1, 16'h0000);
		send_word(skt_pkg::OP_REMOVE, 32'd0, 16'h0000);
		send_word(skt_pkg::OP_LOOKUP, 32'd0, 16'h0000);
		send_word(OP_SPARE, 32'h7fff_ffff, 16'h5a5a);
		send_word(skt_pkg::OP_REMOVE, 32'h7fff_ffff, 16'h0000);
		send_word(skt_pkg::OP_REMOVE, 32'h8000_0000, 16'h0000);
		send_word(skt_pkg::OP_REMOVE, 32'd0, 16'h0000);
		send_word(skt_pkg::OP_REMOVE, 32'hffff_ffff, 16'h0000);
		send_word(skt_pkg::OP_REMOVE, 32'hffff_ffff, 16'h0000);
		drain_results();
	endtask

	task automatic test_full_table(input int idle_pct, input int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		while (held < DEPTH)
			send_word(skt_pkg::OP_INSERT, pick_key(), 16'($urandom()));
		send_word(skt_pkg::OP_INSERT, pick_key(), 16'($urandom()));
		send_word(skt_pkg::OP_INSERT, 32'h8000_0000, 16'hffff);
		send_word(skt_pkg::OP_LOOKUP, held_key[0], 16'($urandom()));
		send_word(skt_pkg::OP_LOOKUP, held_key[DEPTH-1], 16'($urandom()));
		send_word(OP_SPARE, pick_key(), 16'($urandom()));
		while (held > 0) begin
			if ($urandom_range(9) == 0)
				send_word(skt_pkg::OP_REMOVE, $urandom(), 16'($urandom()));
			else
				send_word(skt_pkg::OP_REMOVE, held_key[$urandom_range(held - 1)],
					16'($urandom()));
		end
		drain_results();
	endtask

	task automatic test_random(input int n, input int idle_pct, input int stall_pct);
		int sel;
		int ins_pct;
		logic [skt_pkg::OP_W-1:0] op;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < n; i++) begin
			ins_pct = held < 16 ? 60 : (held > 48 ? 30 : 45);
			sel = $urandom_range(99);
			if (sel < 5)
				op = OP_SPARE;
			else if (sel < 5 + ins_pct)
				op = skt_pkg::OP_INSERT;
			else if (sel < 5 + ins_pct + (95 - ins_pct) / 2)
				op = skt_pkg::OP_REMOVE;
			else
				op = skt_pkg::OP_LOOKUP;
			send_word(op, pick_key(), 16'($urandom()));
		end
		drain_results();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(80, 0, 0);
		test_random(80, 61, 0);
		test_full_table(33, 33);
		test_random(80, 0, 61);
		test_random(80, 33, 33);
		test_full_table(0, 0);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("PASS sorted_key_table_top");
		else
			$display("FAIL sorted_key_table_top");
		$finish;
	end
endmodule
